FILE: src/breathing_led_wave_generator_top_macros.svh
// Assertion macros shared by the breathing LED wave generator.
`ifndef BREATHING_LED_WAVE_GENERATOR_TOP_MACROS_SVH
`define BREATHING_LED_WAVE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define BLWG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blwg assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define BLWG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blwg assertion failed");

`endif

FILE: src/blwg_pkg.sv
// Package with types and constants of the breathing LED wave generator.
package blwg_pkg;

  localparam int DIV_W = 26;
  localparam int DVS_W = 16;
  localparam int DIV_CNT_W = 5;

  localparam logic [31:0] SIN_CA = 32'd1686629713;
  localparam logic [31:0] SIN_CB = 32'd693598668;
  localparam logic [31:0] SIN_CC = 32'd85569306;
  localparam logic [31:0] SIN_CD = 32'd5026995;
  localparam logic [31:0] SIN_CE = 32'd172272;

  typedef enum logic [2:0] {
    REG_IDLE_LEVEL = 3'd0,
    REG_MIN_LEVEL  = 3'd1,
    REG_MAX_LEVEL  = 3'd2,
    REG_SIDE_LEVEL = 3'd3,
    REG_RAMP_MS    = 3'd4,
    REG_FRAME_STEP = 3'd5,
    REG_BREATHE_MS = 3'd6
  } reg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRE_MOD,
    ST_PRE_THETA,
    ST_PRE_WEIGHT,
    ST_PX_START,
    ST_SIN0,
    ST_SIN1,
    ST_SIN2,
    ST_SIN3,
    ST_SIN4,
    ST_SIN5,
    ST_SIN6,
    ST_PX_B,
    ST_PX_C,
    ST_PX_G,
    ST_PX_H,
    ST_PX_R1,
    ST_PX_R2,
    ST_PX_R3,
    ST_EMIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: src/blwg_div.sv
// Restoring divider that produces one quotient bit per cycle.
module blwg_div
  import blwg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  output logic [DIV_W-1:0]   quot,
  output logic [DVS_W-1:0]   rem,
  output div_status_t        status
);

  logic [DVS_W:0]       rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DVS_W:0]       shifted;
  logic                 fits;

  assign shifted = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      quo_q <= dividend;
      dvs_q <= divisor;
    end else if (busy) begin
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign quot        = quo_q;
  assign rem         = rem_q[DVS_W-1:0];
  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: src/breathing_led_wave_generator_top.sv
// Top level of the breathing LED wave generator: sequencer, shared multiplier, registers.
// Sequence: a frame request runs three divider passes, then the per-pixel states (with the
// ramp states added while ramping), then a divider pass for the time update.
// Throughput: one item at a time, set by the shared 32x32 multiplier and bit-serial divider.
// A request with frame_request low is accepted in ST_IDLE and yields no result.
// Reset (rst, synchronous) loads the register defaults and clears phase, ramp and sequencer.
module breathing_led_wave_generator_top
  import blwg_pkg::*;
#(
  parameter int PIXELS       = 22,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        frame_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  pixel_index,
  output logic [7:0]  green_wire,
  output logic [7:0]  red_wire,
  output logic [7:0]  blue_wire,
  output logic        last_pixel
);

`include "breathing_led_wave_generator_top_macros.svh"

  localparam int LOG_W = $clog2(SINE_ENTRIES);
  localparam int ANG_SHIFT = 16 - LOG_W;
  localparam int PIX_W = $clog2(PIXELS);

  logic [6:0]  idle_level, min_level, max_level, side_level;
  logic [15:0] ramp_ms;
  logic [9:0]  frame_step;
  logic [13:0] breathe_ms;

  logic [13:0]       phase_time;
  logic [16:0]       ramp_time;
  logic              ramping;
  logic [PIX_W-1:0]  pix;
  logic [LOG_W-1:0]  theta;
  logic [8:0]        weight;
  logic [15:0]       sin_ang;
  logic              sin_ret;
  logic [15:0]       z;
  logic [30:0]       z2;
  logic signed [16:0] a_val;
  logic [14:0]       cos_val;
  logic [15:0]       acc;
  logic [15:0]       idle_term;
  logic [6:0]        g_lvl;
  logic [6:0]        rb_lvl;
  logic [63:0]       prod;

  state_t state, state_next;

  logic [31:0]      mul_a, mul_b;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;
  div_status_t      div_status;

  logic [LOG_W-1:0] phi_tab [PIXELS];
  logic [15:0]      cang_tab [PIXELS];

  for (genvar gi = 0; gi < PIXELS; gi++) begin : g_tab
    localparam longint DIST = (2 * gi >= PIXELS - 1) ? (2 * gi - (PIXELS - 1))
                                                      : ((PIXELS - 1) - 2 * gi);
    localparam longint PHI = DIST * SINE_ENTRIES / (2 * (PIXELS - 1));
    localparam longint CANG = DIST * 64'd655360000 / (2 * (PIXELS - 1) * 20001) + 16384;
    assign phi_tab[gi]  = LOG_W'(PHI);
    assign cang_tab[gi] = 16'(CANG);
  end

  blwg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .rem      (div_rem),
    .status   (div_status)
  );

  logic [13:0] br;
  logic [15:0] rp;
  logic [6:0]  span;
  logic        last;
  logic [1:0]  quad;
  logic [15:0] z_raw, z_comb;
  logic [31:0] horner_c, horner_t;
  logic [63:0] ysum;
  logic [17:0] y_raw;
  logic [14:0] y_clamp;
  logic [15:0] h_val;
  logic [7:0]  g_sum;
  logic [8:0]  inv_weight;
  logic [16:0] mix_sum;
  logic [LOG_W-1:0] wave_k;
  logic [16:0] ramp_sum;

  assign br         = (breathe_ms == 14'd0) ? 14'd1 : breathe_ms;
  assign rp         = (ramp_ms == 16'd0) ? 16'd1 : ramp_ms;
  assign span       = (max_level > min_level) ? (max_level - min_level) : 7'd0;
  assign last       = pix == PIX_W'(PIXELS - 1);
  assign quad       = sin_ang[15:14];
  assign z_raw      = {1'b0, sin_ang[13:0], 1'b0};
  assign z_comb     = quad[0] ? (16'd32768 - z_raw) : z_raw;
  assign horner_t   = horner_c - prod[61:30];
  assign ysum       = prod + 64'd536870912;
  assign y_raw      = ysum[47:30];
  assign y_clamp    = (y_raw > 18'd32767) ? 15'd32767 : y_raw[14:0];
  assign h_val      = 16'(17'(a_val + 17'sd32768) >> 1);
  assign g_sum      = 8'(min_level) + 8'(prod[21:15]);
  assign inv_weight = 9'd256 - weight;
  assign mix_sum    = 17'(acc) + 17'(prod[15:0]);
  assign wave_k     = theta - phi_tab[pix];
  assign ramp_sum   = ramp_time + 17'(frame_step);

  always_comb begin
    case (state)
      ST_SIN2: horner_c = SIN_CD;
      ST_SIN3: horner_c = SIN_CC;
      ST_SIN4: horner_c = SIN_CB;
      default: horner_c = SIN_CA;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_valid && frame_request) state_next = ST_PRE_MOD;
      ST_PRE_MOD:    if (div_status.done) state_next = ST_PRE_THETA;
      ST_PRE_THETA:  if (div_status.done) state_next = ST_PRE_WEIGHT;
      ST_PRE_WEIGHT: if (div_status.done) state_next = ST_PX_START;
      ST_PX_START:   state_next = ST_SIN0;
      ST_SIN0:       state_next = ST_SIN1;
      ST_SIN1:       state_next = ST_SIN2;
      ST_SIN2:       state_next = ST_SIN3;
      ST_SIN3:       state_next = ST_SIN4;
      ST_SIN4:       state_next = ST_SIN5;
      ST_SIN5:       state_next = ST_SIN6;
      ST_SIN6:       state_next = sin_ret ? ST_PX_B : ST_SIN0;
      ST_PX_B:       state_next = ST_PX_C;
      ST_PX_C:       state_next = ST_PX_G;
      ST_PX_G:       state_next = ST_PX_H;
      ST_PX_H:       state_next = ramping ? ST_PX_R1 : ST_EMIT;
      ST_PX_R1:      state_next = ST_PX_R2;
      ST_PX_R2:      state_next = ST_PX_R3;
      ST_PX_R3:      state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_stall) state_next = last ? ST_FIN : ST_PX_START;
      end
      ST_FIN:        if (div_status.done) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 16'(br);
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        div_start    = in_valid && frame_request;
        div_dividend = DIV_W'(phase_time);
      end
      ST_PRE_MOD: begin
        div_start    = div_status.done;
        div_dividend = DIV_W'(div_rem[13:0]) << LOG_W;
      end
      ST_PRE_THETA: begin
        div_start    = div_status.done;
        div_dividend = DIV_W'({ramp_time, 8'd0});
        div_divisor  = rp;
      end
      ST_SIN0: begin
        mul_a = 32'(z_comb);
        mul_b = 32'(z_comb);
      end
      ST_SIN1: begin
        mul_a = prod[31:0];
        mul_b = SIN_CE;
      end
      ST_SIN2, ST_SIN3, ST_SIN4: begin
        mul_a = 32'(z2);
        mul_b = horner_t;
      end
      ST_SIN5: begin
        mul_a = 32'(z);
        mul_b = horner_t;
      end
      ST_PX_B: begin
        mul_a = 32'(h_val);
        mul_b = 32'(cos_val);
      end
      ST_PX_C: begin
        mul_a = 32'(prod[29:15]);
        mul_b = 32'(prod[29:15]);
      end
      ST_PX_G: begin
        mul_a = 32'(prod[29:15]);
        mul_b = 32'(span);
      end
      ST_PX_H: begin
        mul_a = 32'(g_sum);
        mul_b = 32'(weight);
      end
      ST_PX_R1: begin
        mul_a = 32'(idle_level);
        mul_b = 32'(inv_weight);
      end
      ST_PX_R2: begin
        mul_a = 32'(side_level);
        mul_b = 32'(weight);
      end
      ST_EMIT: begin
        out_valid    = 1'b1;
        div_start    = !out_stall && last;
        div_dividend = DIV_W'(15'(phase_time) + 15'(frame_step));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level <= 7'd0;
      min_level  <= 7'd10;
      max_level  <= 7'd127;
      side_level <= 7'd1;
      ramp_ms    <= 16'd3000;
      frame_step <= 10'd20;
      breathe_ms <= 14'd4000;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IDLE_LEVEL: idle_level <= cfg_wdata[6:0];
        REG_MIN_LEVEL:  min_level  <= cfg_wdata[6:0];
        REG_MAX_LEVEL:  max_level  <= cfg_wdata[6:0];
        REG_SIDE_LEVEL: side_level <= cfg_wdata[6:0];
        REG_RAMP_MS:    ramp_ms    <= cfg_wdata;
        REG_FRAME_STEP: frame_step <= cfg_wdata[9:0];
        REG_BREATHE_MS: breathe_ms <= cfg_wdata[13:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_time <= '0;
      ramp_time  <= '0;
      ramping    <= 1'b1;
      pix        <= '0;
    end else begin
      case (state)
        ST_PRE_WEIGHT: if (div_status.done) pix <= '0;
        ST_EMIT: if (!out_stall && !last) pix <= pix + 1'b1;
        ST_FIN: begin
          if (div_status.done) begin
            pix        <= '0;
            phase_time <= div_rem[13:0];
            if (ramping) begin
              ramp_time <= ramp_sum;
              if (ramp_sum >= 17'(rp)) ramping <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_PRE_THETA: if (div_status.done) theta <= div_quot[LOG_W-1:0];
      ST_PRE_WEIGHT: begin
        if (div_status.done) begin
          weight <= (div_quot > DIV_W'(256)) ? 9'd256 : div_quot[8:0];
        end
      end
      ST_PX_START: begin
        sin_ang <= 16'(wave_k) << ANG_SHIFT;
        sin_ret <= 1'b0;
      end
      ST_SIN0: z <= z_comb;
      ST_SIN1: z2 <= prod[30:0];
      ST_SIN6: begin
        if (!sin_ret) begin
          a_val   <= quad[1] ? -17'(y_clamp) : 17'(y_clamp);
          sin_ang <= cang_tab[pix];
          sin_ret <= 1'b1;
        end else begin
          cos_val <= quad[1] ? 15'd0 : y_clamp;
        end
      end
      ST_PX_H: begin
        g_lvl <= g_sum[6:0];
        if (!ramping) rb_lvl <= side_level;
      end
      ST_PX_R1: acc <= prod[15:0];
      ST_PX_R2: begin
        g_lvl     <= mix_sum[14:8];
        idle_term <= prod[15:0];
      end
      ST_PX_R3: rb_lvl <= 7'((17'(prod[15:0]) + 17'(idle_term)) >> 8);
      default: begin
      end
    endcase
  end

  assign pixel_index = 6'(pix);
  assign green_wire  = {1'b1, g_lvl};
  assign red_wire    = {1'b1, rb_lvl};
  assign blue_wire   = {1'b1, rb_lvl};
  assign last_pixel  = last;

  `BLWG_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall)
  `BLWG_ASSERT_NOW(a_idle_div_quiet, state == ST_IDLE, !div_status.busy)
  `BLWG_ASSERT_NOW(a_side_match, out_valid, green_wire[7] && red_wire == blue_wire)
  `BLWG_ASSERT_NEXT(a_emit_advances, out_valid && !out_stall && !last_pixel,
                    !out_valid && in_stall)

endmodule
